// ===== rtl/qpht_pkg.sv =====
package qpht_pkg;

  // Slot count; a power of two, so the home slot and every probe step wrap by masking.
  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int KEY_W       = 32;
  localparam int OUT_SLOT_W  = 4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_FOUND    = 2'd2;
  localparam logic [1:0] STAT_MISSING  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic term;
    logic out_busy;
  } stat_t;

  function automatic logic [OUT_SLOT_W-1:0] out_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+OUT_SLOT_W-1:0] ext;
    ext = {{OUT_SLOT_W{1'b0}}, s};
    return ext[OUT_SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/qpht_ram.sv =====
module qpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/qpht_ctrl.sv =====
module qpht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  qpht_pkg::stat_t     stat,
  output qpht_pkg::ctrl_t     ctrl
);

  qpht_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qpht_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ctrl        = '0;
    in_tready   = 1'b0;
    case (state_r)
      qpht_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.start = 1'b1;
          state_nxt  = qpht_pkg::ST_PROBE;
        end
      end
      qpht_pkg::ST_PROBE: begin
        ctrl.issue = 1'b1;
        if (stat.term) begin
          ctrl.finish = 1'b1;
          state_nxt   = qpht_pkg::ST_DONE;
        end
      end
      qpht_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          ctrl.emit = 1'b1;
          state_nxt = qpht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = qpht_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/qpht_dp.sv =====
module qpht_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tuser,
  input  logic [qpht_pkg::KEY_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [1:0]                  out_tuser,
  output logic [7:0]                  out_tdata,
  input  qpht_pkg::ctrl_t             ctrl,
  output qpht_pkg::stat_t             stat
);

  localparam int SW = qpht_pkg::SLOT_W;
  localparam int CW = qpht_pkg::CNT_W;
  localparam int N  = qpht_pkg::TABLE_SLOTS;

  logic                       cmd_r;
  logic [qpht_pkg::KEY_W-1:0] key_r;
  logic [SW-1:0]              pos_r;
  logic [SW-1:0]              sq_r;
  logic [SW-1:0]              odd_r;
  logic [CW-1:0]              issued_r;
  logic                       chk_valid_r;
  logic                       chk_occ_r;
  logic                       chk_last_r;
  logic [SW-1:0]              chk_pos_r;
  logic [N-1:0]               occ_r;
  logic [1:0]                 res_status_r;
  logic [qpht_pkg::OUT_SLOT_W-1:0] res_slot_r;
  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic [qpht_pkg::OUT_SLOT_W-1:0] out_slot_r;

  logic [qpht_pkg::KEY_W-1:0] rd_key;
  logic                       can_issue;
  logic                       free_hit;
  logic                       key_hit;
  logic                       wr_en;
  logic [1:0]                 res_status_nxt;
  logic [qpht_pkg::OUT_SLOT_W-1:0] res_slot_nxt;

  qpht_ram #(
    .WIDTH (qpht_pkg::KEY_W),
    .DEPTH (N)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (chk_pos_r),
    .wr_data (key_r),
    .rd_addr (pos_r),
    .rd_data (rd_key)
  );

  assign can_issue = (issued_r != CW'(N));
  assign free_hit  = chk_valid_r && !chk_occ_r;
  assign key_hit   = chk_valid_r && chk_occ_r && (cmd_r == qpht_pkg::CMD_SEARCH)
                     && (rd_key == key_r);
  assign stat.term     = free_hit || key_hit || (chk_valid_r && chk_last_r);
  assign stat.out_busy = out_valid_r && !out_tready;
  assign wr_en = ctrl.finish && free_hit && (cmd_r == qpht_pkg::CMD_INSERT);

  always_comb begin
    res_slot_nxt = '0;
    if (free_hit) begin
      if (cmd_r == qpht_pkg::CMD_INSERT) begin
        res_status_nxt = qpht_pkg::STAT_INSERTED;
        res_slot_nxt   = qpht_pkg::out_slot(chk_pos_r);
      end else begin
        res_status_nxt = qpht_pkg::STAT_MISSING;
      end
    end else if (key_hit) begin
      res_status_nxt = qpht_pkg::STAT_FOUND;
      res_slot_nxt   = qpht_pkg::out_slot(chk_pos_r);
    end else if (cmd_r == qpht_pkg::CMD_INSERT) begin
      res_status_nxt = qpht_pkg::STAT_FULL;
    end else begin
      res_status_nxt = qpht_pkg::STAT_MISSING;
    end
  end

  // probe walk: step i*i mod N added to pos per probe, kept incrementally as sq += 2i+1
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cmd_r <= in_tuser;
      key_r <= in_tdata;
      pos_r <= in_tdata[SW-1:0];
      sq_r  <= SW'(1);
      odd_r <= SW'(3);
    end else if (ctrl.issue && can_issue) begin
      pos_r     <= pos_r + sq_r;
      sq_r      <= sq_r + odd_r;
      odd_r     <= odd_r + SW'(2);
    end
    if (ctrl.issue && can_issue) begin
      chk_pos_r  <= pos_r;
      chk_occ_r  <= occ_r[pos_r];
      chk_last_r <= (issued_r == CW'(N - 1));
    end
    if (ctrl.finish) begin
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
    end
    if (ctrl.emit) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issued_r    <= '0;
      chk_valid_r <= 1'b0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.start) begin
        issued_r <= '0;
      end else if (ctrl.issue && can_issue) begin
        issued_r <= issued_r + CW'(1);
      end
      chk_valid_r <= ctrl.issue && can_issue && !ctrl.finish;
      if (wr_en) begin
        occ_r[chk_pos_r] <= 1'b1;
      end
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(8 - qpht_pkg::OUT_SLOT_W){1'b0}}, out_slot_r};

endmodule

// ===== rtl/quadratic_probe_hash_table.sv =====
// Open-addressed key table with cumulative quadratic probing over TABLE_SLOTS slots
// (qpht_pkg). A transaction carries an insert or a search; each gives one result
// transaction. Work is one transaction at a time: a probe walk issues one key-memory
// read per cycle and checks the registered data, up to a free slot, a key match on a search
// or the last of TABLE_SLOTS probes; the result then leaves once the output register is
// free. A new request is taken while the previous result still waits at the output.
// The table starts empty after reset; duplicate inserts take another slot.
module quadratic_probe_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // [0] command: 0 insert, 1 search
  input  logic [31:0] in_tdata,   // [31:0] key
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [7:0]  out_tdata   // [3:0] slot, [7:4] zero
);

  qpht_pkg::ctrl_t ctrl;
  qpht_pkg::stat_t stat;

  qpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  qpht_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .ctrl       (ctrl),
    .stat       (stat)
  );

endmodule

// ===== tb/quadratic_probe_hash_table_tb.sv =====
module quadratic_probe_hash_table_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1830;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
  } lookup_res_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic        typed;
    logic [1:0]  status;
    logic [3:0]  slot;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic        in_tuser = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [7:0]  out_tdata;

  logic               slot_used [qpht_pkg::TABLE_SLOTS];
  logic [31:0]        slot_key  [qpht_pkg::TABLE_SLOTS];
  lookup_res_t        pending_q [$];
  logic [31:0]        key_pool  [$];
  dir_row_t           directed_rows [0:20];
  int                 err_cnt = 0;
  int                 accepted_cnt = 0;
  int                 cycle_cnt = 0;
  int                 burst_left = 0;

  quadratic_probe_hash_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** quadratic_probe_hash_table: FAILED **");
      $finish;
    end
  end

  // shadow table: walks the cumulative quadratic probe sequence
  function automatic lookup_res_t probe_table(input logic cmd, input logic [31:0] key);
    int pos;
    int n;
    int step;
    bit hit;
    lookup_res_t res;
    pos = int'(key % qpht_pkg::TABLE_SLOTS);
    hit = 1'b0;
    res.slot = '0;
    res.status = (cmd == qpht_pkg::CMD_INSERT) ? qpht_pkg::STAT_FULL : qpht_pkg::STAT_MISSING;
    for (n = 0; n < qpht_pkg::TABLE_SLOTS && !hit; n++) begin
      if (cmd == qpht_pkg::CMD_INSERT) begin
        if (!slot_used[pos]) begin
          slot_used[pos] = 1'b1;
          slot_key[pos] = key;
          res.status = qpht_pkg::STAT_INSERTED;
          res.slot = 4'(pos);
          hit = 1'b1;
        end
      end else begin
        if (!slot_used[pos]) begin
          hit = 1'b1;
        end else if (slot_key[pos] == key) begin
          res.status = qpht_pkg::STAT_FOUND;
          res.slot = 4'(pos);
          hit = 1'b1;
        end
      end
      step = (n + 1) % qpht_pkg::TABLE_SLOTS;
      if (!hit)
        pos = (pos + (step * step) % qpht_pkg::TABLE_SLOTS) % qpht_pkg::TABLE_SLOTS;
    end
    return res;
  endfunction

  task automatic offer(input logic cmd, input logic [31:0] key, input logic typed,
                       input lookup_res_t typed_res);
    int gap;
    lookup_res_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = probe_table(cmd, key);
    if (cmd == qpht_pkg::CMD_INSERT && res.status == qpht_pkg::STAT_INSERTED)
      key_pool.push_back(key);
    pending_q.push_back(typed ? typed_res : res);
    accepted_cnt++;
  endtask

  always @(posedge clk) begin
    lookup_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transaction status=%0d data=%h", $time, out_tuser,
                 out_tdata);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, out_tuser);
          err_cnt++;
        end
        if (out_tdata !== {4'b0, want.slot}) begin
          $display("%0t: slot exp %h got %h", $time, {4'b0, want.slot}, out_tdata);
          err_cnt++;
        end
      end
    end
  end

  // receiver: ready pattern changes per span, one long hold-off
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && accepted_cnt >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 64);
      repeat (span) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int i;
    int r;
    logic        cmd;
    logic [31:0] key;
    lookup_res_t typed_res;
    for (i = 0; i < qpht_pkg::TABLE_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
    end
    // keys with home slot 0 fill every slot that its probe sequence reaches
    directed_rows = '{
      '{qpht_pkg::CMD_SEARCH, 32'h0000_0000, 1'b1, qpht_pkg::STAT_MISSING,  4'd0},
      '{qpht_pkg::CMD_INSERT, 32'h0000_0000, 1'b1, qpht_pkg::STAT_INSERTED, 4'd0},
      '{qpht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b1, qpht_pkg::STAT_INSERTED, 4'd15},
      '{qpht_pkg::CMD_SEARCH, 32'h0000_0000, 1'b1, qpht_pkg::STAT_FOUND,    4'd0},
      '{qpht_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 1'b1, qpht_pkg::STAT_FOUND,    4'd15},
      '{qpht_pkg::CMD_SEARCH, 32'h0000_0010, 1'b0, qpht_pkg::STAT_MISSING,  4'd0},
      '{qpht_pkg::CMD_INSERT, 32'h0000_0010, 1'b0, qpht_pkg::STAT_INSERTED, 4'd0},
      '{qpht_pkg::CMD_INSERT, 32'h0000_0000, 1'b0, qpht_pkg::STAT_INSERTED, 4'd0},
      '{qpht_pkg::CMD_SEARCH, 32'h0000_0000, 1'b1, qpht_pkg::STAT_FOUND,    4'd0},
      '{qpht_pkg::CMD_INSERT, 32'h8000_0000, 1'b0, qpht_pkg::STAT_INSERTED, 4'd0},
      '{qpht_pkg::CMD_INSERT, 32'hFFFF_FFF0, 1'b0, qpht_pkg::STAT_INSERTED, 4'd0},
      '{qpht_pkg::CMD_INSERT, 32'h1234_5670, 1'b0, qpht_pkg::STAT_INSERTED, 4'd0},
      '{qpht_pkg::CMD_INSERT, 32'hA5A5_A5A0, 1'b0, qpht_pkg::STAT_INSERTED, 4'd0},
      '{qpht_pkg::CMD_INSERT, 32'h5A5A_5A50, 1'b0, qpht_pkg::STAT_INSERTED, 4'd0},
      '{qpht_pkg::CMD_INSERT, 32'h0000_0030, 1'b0, qpht_pkg::STAT_INSERTED, 4'd0},
      '{qpht_pkg::CMD_INSERT, 32'h0000_0040, 1'b0, qpht_pkg::STAT_INSERTED, 4'd0},
      '{qpht_pkg::CMD_INSERT, 32'h0000_0050, 1'b0, qpht_pkg::STAT_INSERTED, 4'd0},
      '{qpht_pkg::CMD_INSERT, 32'h0000_0060, 1'b1, qpht_pkg::STAT_FULL,     4'd0},
      '{qpht_pkg::CMD_SEARCH, 32'h0000_0060, 1'b1, qpht_pkg::STAT_MISSING,  4'd0},
      '{qpht_pkg::CMD_SEARCH, 32'h0000_0050, 1'b0, qpht_pkg::STAT_FOUND,    4'd0},
      '{qpht_pkg::CMD_SEARCH, 32'h7FFF_FFFF, 1'b0, qpht_pkg::STAT_MISSING,  4'd0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 21; i++) begin
      typed_res.status = directed_rows[i].status;
      typed_res.slot = directed_rows[i].slot;
      offer(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].typed, typed_res);
    end

    typed_res = '0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        cmd = qpht_pkg::CMD_INSERT;
        case ($urandom_range(0, 3))
          0: key = key_pool[$urandom_range(0, key_pool.size() - 1)];
          1: key = {28'($urandom), 4'(0)} | 32'($urandom_range(0, 15));
          default: key = $urandom;
        endcase
      end else begin
        cmd = qpht_pkg::CMD_SEARCH;
        if (r < 65)
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (r < 85)
          key = $urandom;
        else
          key = key_pool[$urandom_range(0, key_pool.size() - 1)] ^
                (32'h1 << $urandom_range(0, 31));
      end
      offer(cmd, key, 1'b0, typed_res);
    end
    in_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("** quadratic_probe_hash_table: PASSED **");
    else
      $display("** quadratic_probe_hash_table: FAILED **");
    $finish;
  end

endmodule
